>>> rtl/core/lfib4_pkg.sv
// ----------------------------------------------------------------------------
// lfib4_pkg
// Shared types and constants of the four-tap lagged Fibonacci generator.
// ----------------------------------------------------------------------------
package lfib4_pkg;

   localparam int unsigned WORD_W           = 32;
   localparam int unsigned SLOT_W           = 8;
   localparam int unsigned RING_DEPTH       = 256;
   localparam int unsigned TAP_COUNT        = 4;
   localparam int unsigned TAP_LAG [TAP_COUNT] = '{0, 55, 119, 179};

   localparam int unsigned QUEUE_DEPTH      = 4;
   localparam int unsigned OUT_DEPTH        = 4;
   localparam int unsigned OUT_CNT_W        = $clog2(OUT_DEPTH + 1);

   localparam int unsigned REQ_DATA_W       = SLOT_W + WORD_W;
   localparam int unsigned REQ_USER_W       = 1;

   typedef enum logic {
      OP_GENERATE = 1'b0,
      OP_LOAD     = 1'b1
   } op_type;

   typedef struct packed {
      op_type              op;
      logic [SLOT_W-1:0]   addr;
      logic [WORD_W-1:0]   word;
   } cmd_type;

   typedef struct packed {
      logic [OUT_CNT_W-1:0] out_count;
      logic                 inflight;
   } stat_type;

endpackage

>>> rtl/core/lfib4_front.sv
// ----------------------------------------------------------------------------
// lfib4_front
// Accepts items, assigns ring positions to generate items, queues commands.
// ----------------------------------------------------------------------------
module lfib4_front
   import lfib4_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,  // seed_slot[7:0], seed_word[39:8]
   input  logic [REQ_USER_W-1:0] req_tuser,  // op[0]
   output logic                  cmd_valid,
   output cmd_type               cmd,
   input  logic                  cmd_pop
);

   localparam int unsigned Q_AW = $clog2(QUEUE_DEPTH);
   localparam int unsigned Q_CW = $clog2(QUEUE_DEPTH + 1);

   cmd_type           queue_ff [QUEUE_DEPTH];
   logic [Q_AW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [Q_AW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [Q_CW-1:0]   count_ff, count_in;
   logic [SLOT_W-1:0] pos_ff, pos_in;
   logic              accept;
   cmd_type           new_cmd;

   assign req_tready = (count_ff != Q_CW'(QUEUE_DEPTH));
   assign accept     = req_tvalid && req_tready;

   // classify: a generate item takes the next ring position
   always_comb begin
      new_cmd.op   = op_type'(req_tuser[0]);
      new_cmd.word = req_tdata[REQ_DATA_W-1:SLOT_W];
      new_cmd.addr = (new_cmd.op == OP_GENERATE) ? pos_ff : req_tdata[SLOT_W-1:0];
   end

   always_comb begin
      pos_in = pos_ff;
      if (accept && new_cmd.op == OP_GENERATE) begin
         pos_in = pos_ff + SLOT_W'(1);
      end
   end

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (accept) begin
         wr_ptr_in = (wr_ptr_ff == Q_AW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + Q_AW'(1);
      end
      if (cmd_pop) begin
         rd_ptr_in = (rd_ptr_ff == Q_AW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + Q_AW'(1);
      end
   end

   always_comb begin
      unique case ({accept, cmd_pop})
         2'b10:   count_in = count_ff + Q_CW'(1);
         2'b01:   count_in = count_ff - Q_CW'(1);
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
         pos_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
         pos_ff    <= pos_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         queue_ff[wr_ptr_ff] <= new_cmd;
      end
   end

   assign cmd_valid = (count_ff != '0);
   assign cmd       = queue_ff[rd_ptr_ff];

endmodule

>>> rtl/core/lfib4_back.sv
// ----------------------------------------------------------------------------
// lfib4_back
// Lag ring with four read copies, tap sum, write-back and result buffer.
// ----------------------------------------------------------------------------
module lfib4_back
   import lfib4_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              cmd_valid,
   input  cmd_type           cmd,
   output logic              cmd_pop,
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   output logic [WORD_W-1:0] rsp_tdata,  // random_value[31:0]
   output stat_type          stat
);

   localparam int unsigned ADDR_W = $clog2(RING_DEPTH);
   localparam int unsigned O_AW   = $clog2(OUT_DEPTH);

   logic [ADDR_W-1:0]    tap_addr [TAP_COUNT];
   logic [WORD_W-1:0]    tap_val  [TAP_COUNT];
   logic                 issue;
   logic                 room;

   logic                 rd_valid_ff;
   op_type               rd_op_ff;
   logic [ADDR_W-1:0]    rd_addr_ff;
   logic [WORD_W-1:0]    rd_word_ff;
   logic [TAP_COUNT-1:0] rd_fwd_ff;
   logic [TAP_COUNT-1:0] rd_vld_ff;

   logic [RING_DEPTH-1:0] ring_vld_ff;
   logic [WORD_W-1:0]     last_wr_ff;
   logic                  wr_en;
   logic [ADDR_W-1:0]     wr_addr;
   logic [WORD_W-1:0]     wr_data;
   logic [WORD_W-1:0]     tap_sum;

   logic [WORD_W-1:0]    out_mem_ff [OUT_DEPTH];
   logic [O_AW-1:0]      out_wr_ptr_ff, out_wr_ptr_in;
   logic [O_AW-1:0]      out_rd_ptr_ff, out_rd_ptr_in;
   logic [OUT_CNT_W-1:0] out_count_ff, out_count_in;
   logic                 out_push;
   logic                 out_pop;

   // credit check: buffer space for the item in flight plus this one
   assign room  = ({1'b0, out_count_ff} + (OUT_CNT_W + 1)'(rd_valid_ff && rd_op_ff == OP_GENERATE))
                  < (OUT_CNT_W + 1)'(OUT_DEPTH);
   assign issue   = cmd_valid && (cmd.op == OP_LOAD || room);
   assign cmd_pop = issue;

   always_comb begin
      for (int k = 0; k < TAP_COUNT; k++) begin
         tap_addr[k] = cmd.addr[ADDR_W-1:0] - ADDR_W'(TAP_LAG[k]);
      end
   end

   // read stage
   always_ff @(posedge clock) begin
      if (reset) begin
         rd_valid_ff <= 1'b0;
      end else begin
         rd_valid_ff <= issue;
      end
   end

   always_ff @(posedge clock) begin
      rd_op_ff   <= cmd.op;
      rd_addr_ff <= cmd.addr[ADDR_W-1:0];
      rd_word_ff <= cmd.word;
      for (int k = 0; k < TAP_COUNT; k++) begin
         rd_fwd_ff[k] <= wr_en && (wr_addr == tap_addr[k]);
         rd_vld_ff[k] <= ring_vld_ff[tap_addr[k]];
      end
   end

   for (genvar k = 0; k < TAP_COUNT; k++) begin : g_copy
      logic [WORD_W-1:0] ring_mem [RING_DEPTH];
      logic [WORD_W-1:0] rd_data_ff;

      always_ff @(posedge clock) begin
         if (wr_en) begin
            ring_mem[wr_addr] <= wr_data;
         end
         rd_data_ff <= ring_mem[tap_addr[k]];
      end

      // unwritten entries read as zero, the previous write is forwarded
      assign tap_val[k] = rd_fwd_ff[k] ? last_wr_ff :
                          rd_vld_ff[k] ? rd_data_ff : '0;
   end

   // write stage
   assign tap_sum = tap_val[0] + tap_val[1] + tap_val[2] + tap_val[3];
   assign wr_en   = rd_valid_ff;
   assign wr_addr = rd_addr_ff;
   assign wr_data = (rd_op_ff == OP_LOAD) ? rd_word_ff : tap_sum;

   always_ff @(posedge clock) begin
      if (reset) begin
         ring_vld_ff <= '0;
      end else if (wr_en) begin
         ring_vld_ff[wr_addr] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         last_wr_ff <= wr_data;
      end
   end

   // result buffer
   assign out_push = rd_valid_ff && rd_op_ff == OP_GENERATE;
   assign out_pop  = rsp_tvalid && rsp_tready;

   always_comb begin
      out_wr_ptr_in = out_wr_ptr_ff;
      out_rd_ptr_in = out_rd_ptr_ff;
      if (out_push) begin
         out_wr_ptr_in = (out_wr_ptr_ff == O_AW'(OUT_DEPTH - 1)) ? '0
                         : out_wr_ptr_ff + O_AW'(1);
      end
      if (out_pop) begin
         out_rd_ptr_in = (out_rd_ptr_ff == O_AW'(OUT_DEPTH - 1)) ? '0
                         : out_rd_ptr_ff + O_AW'(1);
      end
   end

   always_comb begin
      unique case ({out_push, out_pop})
         2'b10:   out_count_in = out_count_ff + OUT_CNT_W'(1);
         2'b01:   out_count_in = out_count_ff - OUT_CNT_W'(1);
         default: out_count_in = out_count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_wr_ptr_ff <= '0;
         out_rd_ptr_ff <= '0;
         out_count_ff  <= '0;
      end else begin
         out_wr_ptr_ff <= out_wr_ptr_in;
         out_rd_ptr_ff <= out_rd_ptr_in;
         out_count_ff  <= out_count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (out_push) begin
         out_mem_ff[out_wr_ptr_ff] <= tap_sum;
      end
   end

   assign rsp_tvalid     = (out_count_ff != '0);
   assign rsp_tdata      = out_mem_ff[out_rd_ptr_ff];
   assign stat.out_count = out_count_ff;
   assign stat.inflight  = out_push;

endmodule

>>> rtl/core/lagged_fibonacci_four_tap_rng.sv
// ----------------------------------------------------------------------------
// lagged_fibonacci_four_tap_rng
// Four-tap additive lagged Fibonacci random word generator (LFIB4).
// ----------------------------------------------------------------------------
// req channel: one item per handshake; req_tuser[0] is the op (0 generate,
//   1 load), req_tdata carries seed_slot and seed_word for loads.
// rsp channel: one 32-bit word per generate item, an unsigned 0.32 fraction;
//   loads give no result.
// a generate item sums the ring words at lags 0, 55, 119 and 179 from the
//   current position, writes the sum back and advances the position.
// throughput: one item per cycle while the result buffer has room, set by the
//   four ring copies that serve the four taps together with one shared write port.
// path: a request is queued, the ring read stage registers the taps, then
//   the sum is written back to the ring and into the result buffer.
// a 4-entry command queue takes items while the back end waits; a 4-entry
//   result buffer lets the receiver stall; without room there the back end
//   holds generates (loads pass) and req_tready drops once the queue fills.
// reset: ring reads as zero everywhere, position zero, both queues empty;
//   req_tready is high once reset is released.
// ----------------------------------------------------------------------------
module lagged_fibonacci_four_tap_rng
   import lfib4_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,  // seed_slot[7:0], seed_word[39:8]
   input  logic [REQ_USER_W-1:0] req_tuser,  // op[0]
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [WORD_W-1:0]     rsp_tdata   // random_value[31:0]
);

   logic     cmd_valid;
   cmd_type  cmd;
   logic     cmd_pop;
   stat_type stat;

   lfib4_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .cmd_valid  (cmd_valid),
      .cmd        (cmd),
      .cmd_pop    (cmd_pop)
   );

   lfib4_back u_back (
      .clock      (clock),
      .reset      (reset),
      .cmd_valid  (cmd_valid),
      .cmd        (cmd),
      .cmd_pop    (cmd_pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .stat       (stat)
   );

   // result buffer never overcommitted
   a_out_credit : assert property (@(posedge clock) disable iff (reset)
      ({1'b0, stat.out_count} + (OUT_CNT_W + 1)'(stat.inflight))
         <= (OUT_CNT_W + 1)'(OUT_DEPTH))
      else $error("result buffer overcommitted");

   // back end only takes commands that are there
   a_pop_valid : assert property (@(posedge clock) disable iff (reset)
      cmd_pop |-> cmd_valid)
      else $error("command popped from empty queue");

   // rsp_tvalid only rises after a generate item was in the write stage
   a_rsp_source : assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(stat.inflight))
      else $error("result without a generate item");

   a_reset_idle : assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid after reset");

endmodule

>>> test/lfib4_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// lfib4_checker
// Watches both channels of the four-tap lagged Fibonacci generator, keeps a
// shadow ring and position, and compares each result word in order with the
// word the shadow ring predicts.
// ----------------------------------------------------------------------------
module lfib4_checker
   import lfib4_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   input  logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,  // seed_slot[7:0], seed_word[39:8]
   input  logic [REQ_USER_W-1:0] req_tuser,  // op[0]
   input  logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   input  logic [WORD_W-1:0]     rsp_tdata,  // random_value[31:0]
   output int                    error_count,
   output int                    pending_count
);

   localparam logic [SLOT_W-1:0] SHORT_LAG = 8'd55;
   localparam logic [SLOT_W-1:0] MID_LAG   = 8'd119;
   localparam logic [SLOT_W-1:0] LONG_LAG  = 8'd179;

   logic [WORD_W-1:0] shadow_ring [256];
   logic [SLOT_W-1:0] shadow_pos;
   logic [WORD_W-1:0] predicted_words [$];
   int                fail_total = 0;

   always @(posedge clock) begin
      logic [WORD_W-1:0] sum_word;
      logic [WORD_W-1:0] want_word;
      if (reset) begin
         foreach (shadow_ring[i]) shadow_ring[i] = '0;
         shadow_pos = '0;
         predicted_words.delete();
         fail_total = 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (predicted_words.size() == 0) begin
               if (fail_total < 10)
                  $display("unexpected result item %h at %0t", rsp_tdata, $realtime);
               fail_total++;
            end else begin
               want_word = predicted_words.pop_front();
               if (rsp_tdata !== want_word) begin
                  if (fail_total < 10)
                     $display("random_value mismatch: expected %h, got %h at %0t",
                              want_word, rsp_tdata, $realtime);
                  fail_total++;
               end
            end
         end
         if (req_tvalid && req_tready) begin
            if (op_type'(req_tuser[0]) == OP_LOAD) begin
               shadow_ring[req_tdata[SLOT_W-1:0]] = req_tdata[SLOT_W +: WORD_W];
            end else begin
               // slot arithmetic wraps at 8 bits, matching the ring depth
               sum_word = shadow_ring[shadow_pos]
                        + shadow_ring[shadow_pos - SHORT_LAG]
                        + shadow_ring[shadow_pos - MID_LAG]
                        + shadow_ring[shadow_pos - LONG_LAG];
               shadow_ring[shadow_pos] = sum_word;
               shadow_pos = shadow_pos + 8'd1;
               predicted_words.push_back(sum_word);
            end
         end
      end
      error_count   <= fail_total;
      pending_count <= predicted_words.size();
   end

endmodule

>>> test/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Drives seed loads and generate requests into the lagged Fibonacci
// generator under several sender and receiver idling patterns; the checker
// beside the block predicts every random word and counts mismatches.
// ----------------------------------------------------------------------------
module testbench;
   import lfib4_pkg::*;

   localparam int IDLE_LIMIT = 5000;

   logic                  clock      = 1'b0;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata  = '0;  // seed_slot[7:0], seed_word[39:8]
   logic [REQ_USER_W-1:0] req_tuser  = '0;  // op[0]
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [WORD_W-1:0]     rsp_tdata;        // random_value[31:0]

   int error_count;
   int pending_count;
   int send_idle_pct  = 0;
   int recv_stall_pct = 0;
   int idle_cycles    = 0;

   lagged_fibonacci_four_tap_rng DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   lfib4_checker word_check (
      .clock         (clock),
      .reset         (reset),
      .req_tvalid    (req_tvalid),
      .req_tready    (req_tready),
      .req_tdata     (req_tdata),
      .req_tuser     (req_tuser),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_tready    (rsp_tready),
      .rsp_tdata     (rsp_tdata),
      .error_count   (error_count),
      .pending_count (pending_count)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(99) >= recv_stall_pct);
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      wait (idle_cycles >= IDLE_LIMIT);
      $display("tb: failure");
      $finish;
   end

   task automatic send_item(input op_type op, input logic [SLOT_W-1:0] slot,
                            input logic [WORD_W-1:0] word);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= {word, slot};
      do @(posedge clock); while (!req_tready);
   endtask

   // hold the sender until every predicted word has come back
   task automatic drain_results();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
   endtask

   task automatic run_phase(input int item_total);
      int sent;
      int burst;
      sent = 0;
      while (sent < item_total) begin
         if ($urandom_range(15) == 0) begin
            // reseed a burst of random ring slots before generating again
            burst = $urandom_range(12, 4);
            repeat (burst) begin
               send_item(OP_LOAD, SLOT_W'($urandom_range(255)), $urandom);
               sent++;
            end
         end else begin
            send_item(($urandom_range(99) < 20) ? OP_LOAD : OP_GENERATE,
                      SLOT_W'($urandom_range(255)), $urandom);
            sent++;
         end
      end
   endtask

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // generate before seeding, with junk in the ignored fields
      send_item(OP_GENERATE, 8'h00, 32'h0000_0000);
      send_item(OP_GENERATE, 8'hFF, 32'hFFFF_FFFF);
      send_item(OP_GENERATE, 8'hA5, 32'h5A5A_A5A5);
      // position is now 3: seed all four taps of the next generate
      send_item(OP_LOAD, 8'd3,   32'h8000_0001);
      send_item(OP_LOAD, 8'd204, 32'h0000_0001);
      send_item(OP_LOAD, 8'd140, 32'hFFFF_FFFF);
      send_item(OP_LOAD, 8'd80,  32'h0000_0002);
      send_item(OP_GENERATE, 8'h12, 32'hDEAD_BEEF);
      // extreme slots and words
      send_item(OP_LOAD, 8'd0,   32'hFFFF_FFFF);
      send_item(OP_LOAD, 8'd255, 32'h0000_0000);
      send_item(OP_LOAD, 8'hAA,  32'h5555_5555);
      send_item(OP_LOAD, 8'h55,  32'hAAAA_AAAA);
      send_item(OP_LOAD, 8'd5,   32'hFFFF_FFFF);
      send_item(OP_LOAD, 8'd4,   32'hFFFF_FFFE);
      send_item(OP_GENERATE, 8'h00, 32'h0000_0000);
      send_item(OP_GENERATE, 8'hFF, 32'hFFFF_FFFF);
      send_item(OP_GENERATE, 8'h00, 32'h0000_0000);
      // load the slot just generated, then generate again
      send_item(OP_LOAD, 8'd6,   32'h1234_5678);
      send_item(OP_GENERATE, 8'h00, 32'h0000_0000);
      send_item(OP_GENERATE, 8'h00, 32'h0000_0000);
      drain_results();

      run_phase(235);
      drain_results();

      send_idle_pct <= 88;
      run_phase(235);
      drain_results();

      send_idle_pct  <= 0;
      recv_stall_pct <= 88;
      run_phase(235);
      drain_results();

      send_idle_pct  <= 6;
      recv_stall_pct <= 6;
      run_phase(235);
      drain_results();

      repeat (8) @(posedge clock);
      if (error_count == 0 && pending_count == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule

>>> files.f
rtl/core/lfib4_pkg.sv
rtl/core/lfib4_front.sv
rtl/core/lfib4_back.sv
rtl/core/lagged_fibonacci_four_tap_rng.sv
test/lfib4_checker.sv
test/testbench.sv
